// ----- src/mavg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared constants and the control state type of the moving average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int WINDOW_MAX_DEFAULT  = 256;
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int CFG_BITS            = 9;

    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 9'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

// ----- src/moving_average_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter
// Keeps the last window_size samples in a RAM delay line and a running sum,
// and emits the sum divided by the window size, truncated toward zero.
// ----------------------------------------------------------------------------
// Only IDLE takes a request; it registers it and reads the oldest sample
// from the delay line. UPDATE writes the delay line and the sum. DIVIDE runs
// the bit-serial divider once the window is full and is skipped while filling.
// FINISH loads the result once the output is free, then returns to IDLE.
// Reset clears the sum, write pointer and fill count and sets the window to
// 16; the delay line RAM is not cleared.
// ----------------------------------------------------------------------------
module moving_average_filter #(
    parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEFAULT,
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          window_size_we,
    input  logic [mavg_pkg::CFG_BITS-1:0] window_size,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SAMPLE_BITS-1:0]        sample,
    input  logic                          end_of_record,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [SAMPLE_BITS-1:0]        average,
    output logic                          full_res,
    output logic                          last
);

    localparam int PTR_BITS = $clog2(WINDOW_MAX);
    localparam int WIN_BITS = $clog2(WINDOW_MAX + 1);
    localparam int EXT_BITS = (WIN_BITS > mavg_pkg::CFG_BITS) ? WIN_BITS : mavg_pkg::CFG_BITS;
    localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS + 1;
    localparam int MAG_BITS = SUM_BITS - 1;

    localparam logic [WIN_BITS:0]   WMAX_W   = (WIN_BITS + 1)'(WINDOW_MAX);
    localparam logic [EXT_BITS-1:0] WMAX_E   = EXT_BITS'(WINDOW_MAX);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(WINDOW_MAX - 1);

    mavg_pkg::state_t state_reg;
    mavg_pkg::state_t state_next;

    logic [mavg_pkg::CFG_BITS-1:0] window_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic signed [SUM_BITS-1:0]    sum_next;
    logic [PTR_BITS-1:0]           wp_reg;
    logic [PTR_BITS-1:0]           wp_next;
    logic [WIN_BITS-1:0]           fill_reg;
    logic [WIN_BITS-1:0]           fill_next;

    logic [SAMPLE_BITS-1:0]        sample_reg;
    logic                          eor_reg;
    logic                          neg_reg;
    logic                          full_reg;

    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        average_reg;
    logic [SAMPLE_BITS-1:0]        average_next;
    logic                          full_res_reg;
    logic                          last_reg;

    logic [EXT_BITS-1:0]           win_ext;
    logic [WIN_BITS-1:0]           w_eff;
    logic [WIN_BITS:0]             wp_ext;
    logic [WIN_BITS:0]             w_ext;
    logic [WIN_BITS:0]             old_idx;
    logic [PTR_BITS-1:0]           old_addr;
    logic                          was_full;
    logic                          now_full;
    logic [SAMPLE_BITS-1:0]        old_sample;
    logic signed [SUM_BITS-1:0]    old_term;
    logic signed [SUM_BITS-1:0]    new_term;
    logic [SUM_BITS-1:0]           sum_abs;
    logic [MAG_BITS-1:0]           quotient;
    logic [MAG_BITS-1:0]           quo_signed;
    logic                          div_done;

    logic                          accept;
    logic                          ram_rd_en;
    logic                          ram_wr_en;
    logic                          div_start;
    logic                          load_out;
    logic                          out_free;

    always_comb
    begin
        win_ext = EXT_BITS'(window_reg);
        if (win_ext == '0)
        begin
            win_ext = EXT_BITS'(1);
        end
        else if (win_ext > WMAX_E)
        begin
            win_ext = WMAX_E;
        end
        w_eff = win_ext[WIN_BITS-1:0];
    end

    always_comb
    begin
        wp_ext = (WIN_BITS + 1)'(wp_reg);
        w_ext  = (WIN_BITS + 1)'(w_eff);
        if (wp_ext >= w_ext)
        begin
            old_idx = wp_ext - w_ext;
        end
        else
        begin
            old_idx = wp_ext + WMAX_W - w_ext;
        end
        old_addr = old_idx[PTR_BITS-1:0];
    end

    always_comb
    begin
        was_full  = (fill_reg >= w_eff);
        fill_next = was_full ? fill_reg : fill_reg + 1'b1;
        now_full  = (fill_next >= w_eff);
        wp_next   = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
        new_term  = SUM_BITS'($signed(sample_reg));
        old_term  = was_full ? SUM_BITS'($signed(old_sample)) : '0;
        sum_next  = sum_reg + new_term - old_term;
        sum_abs   = sum_next[SUM_BITS-1] ? (-sum_next) : sum_next;
    end

    always_comb
    begin
        quo_signed   = neg_reg ? (-quotient) : quotient;
        average_next = full_reg ? quo_signed[SAMPLE_BITS-1:0] : '0;
        out_free     = !out_valid_reg || !out_stall;
    end

    mavg_ram #(
        .DATA_BITS (SAMPLE_BITS),
        .DEPTH     (WINDOW_MAX)
    ) u_delay_line (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (old_addr),
        .rd_data (old_sample)
    );

    mavg_div #(
        .DIVIDEND_BITS (MAG_BITS),
        .DIVISOR_BITS  (WIN_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_abs[MAG_BITS-1:0]),
        .divisor  (w_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mavg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mavg_pkg::ST_UPDATE;
                end
            end
            mavg_pkg::ST_UPDATE:
            begin
                state_next = now_full ? mavg_pkg::ST_DIVIDE : mavg_pkg::ST_FINISH;
            end
            mavg_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = mavg_pkg::ST_FINISH;
                end
            end
            mavg_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mavg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mavg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        accept    = 1'b0;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            mavg_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                accept    = in_valid;
                ram_rd_en = in_valid;
            end
            mavg_pkg::ST_UPDATE:
            begin
                ram_wr_en = 1'b1;
                div_start = now_full;
            end
            mavg_pkg::ST_DIVIDE:
            begin
            end
            mavg_pkg::ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mavg_pkg::ST_IDLE;
            window_reg    <= mavg_pkg::WINDOW_RESET;
            sum_reg       <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (window_size_we)
            begin
                window_reg <= window_size;
                sum_reg    <= '0;
                fill_reg   <= '0;
            end
            else if (state_reg == mavg_pkg::ST_UPDATE)
            begin
                sum_reg  <= eor_reg ? '0 : sum_next;
                fill_reg <= eor_reg ? '0 : fill_next;
            end
            if (state_reg == mavg_pkg::ST_UPDATE)
            begin
                wp_reg <= wp_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            eor_reg    <= end_of_record;
        end
        if (state_reg == mavg_pkg::ST_UPDATE)
        begin
            neg_reg  <= sum_next[SUM_BITS-1];
            full_reg <= now_full;
        end
        if (load_out)
        begin
            average_reg  <= average_next;
            full_res_reg <= full_reg;
            last_reg     <= eor_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;
    assign full_res  = full_res_reg;
    assign last      = last_reg;

endmodule

// ----- src/mavg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mavg_ram #(
    parameter int DATA_BITS = 16,
    parameter int DEPTH     = 256
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [DATA_BITS-1:0]         wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_BITS-1:0]         rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/mavg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mavg_div #(
    parameter int DIVIDEND_BITS = 24,
    parameter int DIVISOR_BITS  = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg;
    logic                     busy_next;
    logic                     done_reg;
    logic                     done_next;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [CNT_BITS-1:0]      cnt_next;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVIDEND_BITS-1:0] quo_next;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [DIVISOR_BITS-1:0]  div_reg;
    logic [DIVISOR_BITS-1:0]  div_next;

    logic [DIVISOR_BITS:0]    rem_shift;
    logic [DIVISOR_BITS:0]    rem_diff;
    logic                     fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        fits      = (rem_shift >= {1'b0, div_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DIVIDEND_BITS);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_next = fits ? rem_diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- dv/tb_moving_average_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter testbench
// Sends signed sample requests with end-of-record marks through the filter at
// several window sizes. A built-in predictor works out the expected average,
// fill flag and last flag for each accepted request. Each result is checked in
// order against that prediction; in some phases both sides idle at random.
// ----------------------------------------------------------------------------
module tb_moving_average_filter;

    localparam int DEPTH         = mavg_pkg::WINDOW_MAX_DEFAULT;
    localparam int SBITS         = mavg_pkg::SAMPLE_BITS_DEFAULT;
    localparam int CFG_W         = mavg_pkg::CFG_BITS;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_WINDOW = -1;

    typedef struct packed {
        logic signed [SBITS-1:0] average;
        logic                    full_res;
        logic                    last;
    } avg_result_t;

    logic                clk;
    logic                rst_n;
    logic                window_size_we;
    logic [CFG_W-1:0]    window_size;
    logic                in_valid;
    logic                in_stall;
    logic [SBITS-1:0]    sample;
    logic                end_of_record;
    logic                out_valid;
    logic                out_stall;
    logic [SBITS-1:0]    average;
    logic                full_res;
    logic                last;

    avg_result_t expected_averages[$];
    int          error_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;

    logic signed [SBITS-1:0] delay_mem [DEPTH];
    longint                  run_sum;
    int                      wr_ptr;
    int                      fill_cnt;
    logic [CFG_W-1:0]        win_reg;

    int phase_windows [3][5] = '{
        '{2, 256, 5, RANDOM_WINDOW, 0},
        '{511, 7, 1, RANDOM_WINDOW, 3},
        '{16, RANDOM_WINDOW, 9, RANDOM_WINDOW, 2}
    };

    moving_average_filter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_size_we (window_size_we),
        .window_size    (window_size),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .end_of_record  (end_of_record),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .average        (average),
        .full_res       (full_res),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int effective_window(input logic [CFG_W-1:0] value);
        int w;
        w = value;
        if (w == 0)
            w = 1;
        if (w > DEPTH)
            w = DEPTH;
        return w;
    endfunction

    function automatic avg_result_t predict_average(input logic signed [SBITS-1:0] value,
                                                    input logic eor);
        int          w;
        longint      quotient;
        avg_result_t r;
        w = effective_window(win_reg);
        if (fill_cnt >= w)
            run_sum -= delay_mem[(wr_ptr + DEPTH - w) % DEPTH];
        delay_mem[wr_ptr] = value;
        run_sum += value;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (fill_cnt < w)
            fill_cnt++;
        r.average  = '0;
        r.full_res = 1'b0;
        r.last     = eor;
        if (fill_cnt >= w)
        begin
            quotient   = run_sum / longint'(w);
            r.average  = quotient[SBITS-1:0];
            r.full_res = 1'b1;
        end
        if (eor)
        begin
            fill_cnt = 0;
            run_sum  = 0;
        end
        return r;
    endfunction

    function automatic logic [SBITS-1:0] random_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(8)) - 16'd4;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    always @(posedge clk)
    begin : check_results
        avg_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_averages.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, %s %0d full_res %0b last %0b",
                         $time, "actual average", $signed(average), full_res, last);
                error_count++;
            end
            else
            begin
                want = expected_averages.pop_front();
                if (average !== want.average)
                begin
                    $display("%0t: average mismatch, expected %0d, actual %0d",
                             $time, want.average, $signed(average));
                    error_count++;
                end
                if (full_res !== want.full_res)
                begin
                    $display("%0t: full_res mismatch, expected %0b, actual %0b",
                             $time, want.full_res, full_res);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, last);
                    error_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || window_size_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request or result accepted for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_request(input logic [SBITS-1:0] value, input logic eor);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        sample        <= value;
        end_of_record <= eor;
        do
            @(posedge clk);
        while (in_stall);
        expected_averages.push_back(predict_average(value, eor));
    endtask

    // Writing the window size restarts the fill, so it waits until every result is out.
    task automatic set_window(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        wait (expected_averages.size() == 0);
        @(posedge clk);
        window_size_we <= 1'b1;
        window_size    <= value;
        @(posedge clk);
        window_size_we <= 1'b0;
        win_reg  = value;
        fill_cnt = 0;
        run_sum  = 0;
    endtask

    task automatic test_extreme_samples();
        set_window(CFG_W'(4));
        repeat (4) send_request(16'h7FFF, 1'b0);
        repeat (3) send_request(16'h8000, 1'b0);
        send_request(16'h8000, 1'b1);
        repeat (3) send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'h0002, 1'b0);
        send_request(16'h0007, 1'b0);
        send_request(16'h0009, 1'b1);
        send_request(16'h0003, 1'b0);
        send_request(16'hFFF0, 1'b0);
        send_request(16'h0011, 1'b1);
    endtask

    task automatic test_window_limits();
        set_window(CFG_W'(1));
        send_request(16'h7FFF, 1'b0);
        send_request(16'h8000, 1'b0);
        send_request(16'h5555, 1'b0);
        send_request(16'hAAAA, 1'b1);
        set_window(CFG_W'(0));
        send_request(16'hFFFB, 1'b0);
        send_request(16'h000C, 1'b1);
    endtask

    task automatic test_random_records(input int phase);
        int w;
        int eff;
        int budget;
        int sent;
        int rec_len;
        case (phase)
            0:
            begin
                send_idle_pct  = 18;
                recv_stall_pct = 65;
            end
            1:
            begin
                send_idle_pct  = 65;
                recv_stall_pct = 18;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
        for (int k = 0; k < 5; k++)
        begin
            w = phase_windows[phase][k];
            if (w == RANDOM_WINDOW)
                w = $urandom_range(1, 24);
            set_window(CFG_W'(w));
            eff    = effective_window(CFG_W'(w));
            budget = (eff > 32) ? eff + 48 : 60;
            sent   = 0;
            while (sent < budget)
            begin
                if (eff > 32)
                    rec_len = eff + $urandom_range(0, 40);
                else if ($urandom_range(99) < 70)
                    rec_len = eff + $urandom_range(0, eff + 8);
                else
                    rec_len = $urandom_range(1, eff);
                for (int i = 0; i < rec_len && sent < budget; i++)
                begin
                    send_request(random_sample(), i == rec_len - 1);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        window_size_we <= 1'b0;
        window_size    <= mavg_pkg::WINDOW_RESET;
        in_valid       <= 1'b0;
        sample         <= '0;
        end_of_record  <= 1'b0;
        run_sum  = 0;
        wr_ptr   = 0;
        fill_cnt = 0;
        win_reg  = mavg_pkg::WINDOW_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_samples();
        test_window_limits();
        for (int p = 0; p < 3; p++)
            test_random_records(p);
        in_valid <= 1'b0;
        wait (expected_averages.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
